>>> sv/mlsp_pkg.sv
// mlsp_pkg: shared types and constants for the mpls label stack pop block
// no dependencies
`timescale 1ns / 1ps

package mlsp_pkg;

  localparam int AddrBytes  = 12;
  localparam int EtypeBytes = 2;
  localparam int LabelBytes = 4;
  localparam int BurstLen   = AddrBytes + EtypeBytes + 1;
  localparam int CountW     = 4;
  localparam int AddrIdxW   = $clog2(AddrBytes);
  localparam int LabelIdxW  = $clog2(LabelBytes);

  localparam logic [3:0] IpV4 = 4'd4;
  localparam logic [3:0] IpV6 = 4'd6;

  localparam logic [7:0] EtypeV4Hi = 8'h08;
  localparam logic [7:0] EtypeV4Lo = 8'h00;
  localparam logic [7:0] EtypeV6Hi = 8'h86;
  localparam logic [7:0] EtypeV6Lo = 8'hDD;

  localparam logic CmdSingle = 1'b0;
  localparam logic CmdBurst  = 1'b1;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] data;
    logic       last;
    logic       drop;
  } cmd_t;

  typedef struct packed {
    logic                en;
    logic [AddrIdxW-1:0] addr;
    logic [7:0]          data;
  } addr_wr_t;

endpackage

>>> sv/mlsp_ifs.sv
// mlsp_in_if / mlsp_out_if: valid-ready channels for frame bytes and results
// no dependencies
`timescale 1ns / 1ps

interface mlsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface mlsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_drop;

  modport source (output valid, output out_byte, output out_last, output out_drop,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input out_drop,
                  output ready);
endinterface

>>> sv/mpls_label_stack_pop_top.sv
// Takes one frame byte per cycle unless stalled and strips the mpls label
// stack: the 12 address bytes are held, the ethertype and labels are
// consumed, and on the byte after the bottom label the frame is rewritten
// with ethertype 0x0800 or 0x86DD. The version byte of a kept frame yields
// a burst of 15 items, one per cycle from the result register while result
// ready allows, and input stalls until the last of them enters that
// register. A dropped frame (bad version, early end, too many labels) yields
// one item with the drop flag on its last byte. Items pass through a command
// register and then the result register, which together buffer two.
// No clearing pass after reset.
// depends on mlsp_pkg, mlsp_ifs, mlsp_parse, mlsp_emit
`timescale 1ns / 1ps

module mpls_label_stack_pop_top #(
  parameter int MAX_LABELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  mlsp_in_if.sink     frame,
  mlsp_out_if.source  result
);

  mlsp_pkg::cmd_t     cmd;
  mlsp_pkg::addr_wr_t addr_wr;
  logic               cmd_ready;

  mlsp_parse #(
    .MAX_LABELS (MAX_LABELS)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .frame     (frame),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .addr_wr   (addr_wr)
  );

  mlsp_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .cmd_in    (cmd),
    .addr_wr   (addr_wr),
    .cmd_ready (cmd_ready),
    .result    (result)
  );

endmodule

>>> sv/mlsp_parse.sv
// mlsp_parse: per-byte frame parser, walks addresses, ethertype and labels
// depends on mlsp_pkg and mlsp_in_if; issues commands to mlsp_emit
`timescale 1ns / 1ps

module mlsp_parse #(
  parameter int MAX_LABELS = 8
) (
  input  logic                clk,
  input  logic                rst,
  mlsp_in_if.sink             frame,
  input  logic                cmd_ready,
  output mlsp_pkg::cmd_t      cmd,
  output mlsp_pkg::addr_wr_t  addr_wr
);

  localparam logic [2:0] PhAddr  = 3'd0;
  localparam logic [2:0] PhEtype = 3'd1;
  localparam logic [2:0] PhLabel = 3'd2;
  localparam logic [2:0] PhVer   = 3'd3;
  localparam logic [2:0] PhPass  = 3'd4;

  localparam int CW = mlsp_pkg::CountW;
  localparam int LW = mlsp_pkg::LabelIdxW;

  logic [2:0]    phase, phase_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [LW-1:0] label_byte_index, label_byte_index_next;
  logic          bottom_seen, bottom_seen_next;
  logic [CW-1:0] label_count, label_count_next;
  logic          discarding, discarding_next;

  logic          acc;
  logic          check_last;
  logic          go_idle;
  logic [CW-1:0] bc_inc;
  logic [CW-1:0] lc_inc;
  logic [3:0]    version;

  assign frame.ready = cmd_ready;
  assign acc         = frame.valid && frame.ready;
  assign bc_inc      = byte_count + CW'(1);
  assign lc_inc      = label_count + CW'(1);
  assign version     = frame.in_byte[7:4];

  always_comb begin
    phase_next            = phase;
    byte_count_next       = byte_count;
    label_byte_index_next = label_byte_index;
    bottom_seen_next      = bottom_seen;
    label_count_next      = label_count;
    discarding_next       = discarding;
    check_last            = 1'b0;
    go_idle               = 1'b0;
    cmd                   = '0;
    addr_wr.en            = 1'b0;
    addr_wr.addr          = byte_count[mlsp_pkg::AddrIdxW-1:0];
    addr_wr.data          = frame.in_byte;

    if (acc) begin
      check_last = 1'b1;
      if (!discarding) begin
        unique case (phase)
          PhAddr: begin
            addr_wr.en = 1'b1;
            if (bc_inc >= CW'(mlsp_pkg::AddrBytes)) begin
              phase_next      = PhEtype;
              byte_count_next = '0;
            end else begin
              byte_count_next = bc_inc;
            end
          end
          PhEtype: begin
            if (bc_inc >= CW'(mlsp_pkg::EtypeBytes)) begin
              phase_next            = PhLabel;
              byte_count_next       = '0;
              label_byte_index_next = '0;
              bottom_seen_next      = 1'b0;
            end else begin
              byte_count_next = bc_inc;
            end
          end
          PhLabel: begin
            if (label_byte_index == LW'(2)) begin
              bottom_seen_next = frame.in_byte[0];
            end
            if (label_byte_index == LW'(mlsp_pkg::LabelBytes - 1)) begin
              label_count_next      = lc_inc;
              label_byte_index_next = '0;
              if (bottom_seen) begin
                phase_next = PhVer;
              end else if (lc_inc >= CW'(MAX_LABELS)) begin
                discarding_next = 1'b1;
              end
              bottom_seen_next = 1'b0;
            end else begin
              label_byte_index_next = label_byte_index + LW'(1);
            end
          end
          PhVer: begin
            if (version == mlsp_pkg::IpV4 || version == mlsp_pkg::IpV6) begin
              cmd.valid  = 1'b1;
              cmd.kind   = mlsp_pkg::CmdBurst;
              cmd.data   = frame.in_byte;
              cmd.last   = frame.in_last;
              cmd.drop   = 1'b0;
              check_last = 1'b0;
              if (frame.in_last) begin
                go_idle = 1'b1;
              end else begin
                phase_next = PhPass;
              end
            end else begin
              discarding_next = 1'b1;
            end
          end
          PhPass: begin
            cmd.valid  = 1'b1;
            cmd.kind   = mlsp_pkg::CmdSingle;
            cmd.data   = frame.in_byte;
            cmd.last   = frame.in_last;
            cmd.drop   = 1'b0;
            check_last = 1'b0;
            go_idle    = frame.in_last;
          end
          default: begin
            go_idle = 1'b1;
          end
        endcase
      end

      if (check_last && frame.in_last) begin
        cmd.valid = 1'b1;
        cmd.kind  = mlsp_pkg::CmdSingle;
        cmd.data  = '0;
        cmd.last  = 1'b1;
        cmd.drop  = 1'b1;
        go_idle   = 1'b1;
      end
    end

    if (go_idle) begin
      phase_next            = PhAddr;
      byte_count_next       = '0;
      label_byte_index_next = '0;
      bottom_seen_next      = 1'b0;
      label_count_next      = '0;
      discarding_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PhAddr;
      byte_count       <= '0;
      label_byte_index <= '0;
      bottom_seen      <= 1'b0;
      label_count      <= '0;
      discarding       <= 1'b0;
    end else begin
      phase            <= phase_next;
      byte_count       <= byte_count_next;
      label_byte_index <= label_byte_index_next;
      bottom_seen      <= bottom_seen_next;
      label_count      <= label_count_next;
      discarding       <= discarding_next;
    end
  end

  a_label_bound: assert property (@(posedge clk) disable iff (rst)
    label_count <= CW'(MAX_LABELS))
    else $error("label count beyond limit");

  a_addr_phase_count: assert property (@(posedge clk) disable iff (rst)
    phase == PhAddr |-> byte_count < CW'(mlsp_pkg::AddrBytes))
    else $error("address byte count out of range");

  a_discard_drop_only: assert property (@(posedge clk) disable iff (rst)
    discarding && cmd.valid |-> cmd.drop)
    else $error("discarded frame issued a data command");

endmodule

>>> sv/mlsp_emit.sv
// mlsp_emit: address store, command register and result register
// depends on mlsp_pkg and mlsp_out_if; fed by mlsp_parse
`timescale 1ns / 1ps

module mlsp_emit (
  input  logic                clk,
  input  logic                rst,
  input  mlsp_pkg::cmd_t      cmd_in,
  input  mlsp_pkg::addr_wr_t  addr_wr,
  output logic                cmd_ready,
  mlsp_out_if.source          result
);

  localparam int IW = $clog2(mlsp_pkg::BurstLen);

  logic [7:0]    address_store [mlsp_pkg::AddrBytes];
  mlsp_pkg::cmd_t cmd;
  logic [IW-1:0] idx;
  logic          out_valid;
  logic [7:0]    out_byte;
  logic          out_last;
  logic          out_drop;

  logic          slot_free;
  logic          step;
  logic          cmd_done;
  logic          is_v4;
  logic [7:0]    res_byte;
  logic          res_last;
  logic          res_drop;

  assign slot_free = !out_valid || result.ready;
  assign step      = cmd.valid && slot_free;
  assign cmd_done  = step && (cmd.kind == mlsp_pkg::CmdSingle ||
                              idx == IW'(mlsp_pkg::BurstLen - 1));
  assign cmd_ready = !cmd.valid || cmd_done;
  assign is_v4     = cmd.data[7:4] == mlsp_pkg::IpV4;

  always_comb begin
    res_byte = cmd.data;
    res_last = cmd.last;
    res_drop = cmd.drop;
    if (cmd.kind == mlsp_pkg::CmdBurst) begin
      priority if (idx < IW'(mlsp_pkg::AddrBytes)) begin
        res_byte = address_store[idx[mlsp_pkg::AddrIdxW-1:0]];
        res_last = 1'b0;
      end else if (idx == IW'(mlsp_pkg::AddrBytes)) begin
        res_byte = is_v4 ? mlsp_pkg::EtypeV4Hi : mlsp_pkg::EtypeV6Hi;
        res_last = 1'b0;
      end else if (idx == IW'(mlsp_pkg::AddrBytes + 1)) begin
        res_byte = is_v4 ? mlsp_pkg::EtypeV4Lo : mlsp_pkg::EtypeV6Lo;
        res_last = 1'b0;
      end else begin
        res_byte = cmd.data;
        res_last = cmd.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (addr_wr.en) begin
      address_store[addr_wr.addr] <= addr_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd_ready) begin
        cmd.valid <= cmd_in.valid;
        idx       <= '0;
      end else if (step) begin
        idx <= idx + IW'(1);
      end
      if (slot_free) begin
        out_valid <= cmd.valid;
      end
    end
    if (cmd_ready) begin
      cmd.kind <= cmd_in.kind;
      cmd.data <= cmd_in.data;
      cmd.last <= cmd_in.last;
      cmd.drop <= cmd_in.drop;
    end
    if (step) begin
      out_byte <= res_byte;
      out_last <= res_last;
      out_drop <= res_drop;
    end
  end

  assign result.valid    = out_valid;
  assign result.out_byte = out_byte;
  assign result.out_last = out_last;
  assign result.out_drop = out_drop;

  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && !cmd_done |=> cmd.valid && $stable(cmd.data) && $stable(cmd.kind))
    else $error("command lost before it was fully emitted");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= IW'(mlsp_pkg::BurstLen - 1))
    else $error("burst index out of range");

  a_single_idx: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.kind == mlsp_pkg::CmdSingle |-> idx == '0)
    else $error("single command with nonzero burst index");

  a_drop_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_drop |-> out_last && out_byte == 8'h00)
    else $error("drop item not a final zero byte");

endmodule
